FILE: rtl/core/akpt_pkg.sv
// Shared constants, types and codes for the address-keyed linear probe table.
// No dependencies; every other file of the block refers to this package by scoped names.
package akpt_pkg;

  localparam int TABLE_DEPTH = 64;  // power of two: the home slot is the low key bits
  localparam int KEY_BITS    = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 48;
  localparam int FRAME_W     = 7;
  localparam int HANDLE_W    = 32;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_t;

  typedef struct packed {
    key_t    key;
    frame_t  frames;
    handle_t handle;
  } slot_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } slot_wr_t;

endpackage

FILE: rtl/core/akpt_req_if.sv
// Request channel: valid/ready handshake carrying one table request per beat.
// Depends on akpt_pkg for field widths.
interface akpt_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [akpt_pkg::ADDR_W-1:0]   address;
  logic [akpt_pkg::FRAME_W-1:0]  frame_count;
  logic [akpt_pkg::HANDLE_W-1:0] stack_handle;

  modport source (output valid, req_type, address, frame_count, stack_handle, input ready);
  modport sink   (input valid, req_type, address, frame_count, stack_handle, output ready);
endinterface

FILE: rtl/core/akpt_rsp_if.sv
// Result channel: valid/ready handshake carrying one result per beat.
// Depends on akpt_pkg for field widths.
interface akpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [akpt_pkg::FRAME_W-1:0]  freed_frame_count;
  logic [akpt_pkg::HANDLE_W-1:0] freed_handle;

  modport source (output valid, status, freed_frame_count, freed_handle, input ready);
  modport sink   (input valid, status, freed_frame_count, freed_handle, output ready);
endinterface

FILE: rtl/core/address_keyed_linear_probe_table_core.sv
// Top level of the address-keyed linear probe table; uses akpt_pkg, akpt_req_if, akpt_rsp_if
// and akpt_slot_mem.
//
// Open-addressed table of TABLE_DEPTH slots keyed by address; the home slot is the low key
// bits. One request at a time: after a request beat is taken, one probe step runs per clock
// (valid bit plus key compare against the registered read of that slot) until the probe stops
// on an empty slot, a match or the wrap back to home; clear and the unused request code do not
// probe. The probe rate is set by the single read port of the slot memory.
// The result lands in an output register, so the next request is taken while it waits; a
// probe that finishes while that register is still full waits for it to drain. Valid bits
// are flops cleared by reset and by clear, so no clearing pass is needed.
module address_keyed_linear_probe_table_core (
  input  logic        clk,
  input  logic        rst_n,
  akpt_req_if.sink    in_req,
  akpt_rsp_if.source  out_rsp
);

  akpt_pkg::state_t state_r, state_nxt;

  logic [1:0]          req_r;
  akpt_pkg::key_t      key_r;
  akpt_pkg::idx_t      home_r;
  akpt_pkg::frame_t    frames_r;
  akpt_pkg::handle_t   handle_r;
  akpt_pkg::idx_t      pos_r;
  logic [akpt_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r, status_nxt;
  akpt_pkg::frame_t    freed_fr_r, freed_fr_nxt;
  akpt_pkg::handle_t   freed_hd_r, freed_hd_nxt;

  akpt_pkg::key_t      key_in;
  akpt_pkg::idx_t      rd_addr, pos_inc;
  akpt_pkg::slot_t     rd_data, wr_data;
  akpt_pkg::slot_wr_t  wr;

  logic in_fire, out_free, cur_valid, cur_hit, wrapped, is_probe, stop, finish;

  assign key_in   = akpt_pkg::KEY_BITS'(in_req.address);
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  // probe step: one slot per cycle, data for pos_r was read the cycle before
  assign cur_valid = valid_r[pos_r];
  assign cur_hit   = cur_valid && (rd_data.key == key_r);
  assign pos_inc   = akpt_pkg::idx_t'(pos_r + 1'b1);
  assign wrapped   = (pos_inc == home_r);
  assign is_probe  = (req_r == akpt_pkg::REQ_INSERT) || (req_r == akpt_pkg::REQ_REMOVE);
  assign stop      = !is_probe || !cur_valid || cur_hit || wrapped;
  assign finish    = (state_r == akpt_pkg::S_PROBE) && stop && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      akpt_pkg::S_IDLE: begin
        if (in_fire) state_nxt = akpt_pkg::S_PROBE;
      end
      akpt_pkg::S_PROBE: begin
        if (finish) state_nxt = akpt_pkg::S_IDLE;
      end
      default: state_nxt = akpt_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_req.ready  = (state_r == akpt_pkg::S_IDLE);
    rd_addr       = key_in[akpt_pkg::IDX_W-1:0];
    valid_nxt     = valid_r;
    wr.en         = 1'b0;
    wr.addr       = pos_r;
    wr_data.key    = key_r;
    wr_data.frames = frames_r;
    wr_data.handle = handle_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = status_r;
    freed_fr_nxt  = freed_fr_r;
    freed_hd_nxt  = freed_hd_r;

    if (state_r == akpt_pkg::S_PROBE) begin
      rd_addr = stop ? pos_r : pos_inc;
    end

    if (finish) begin
      out_valid_nxt = 1'b1;
      status_nxt    = akpt_pkg::ST_OK;
      freed_fr_nxt  = '0;
      freed_hd_nxt  = '0;
      case (req_r)
        akpt_pkg::REQ_INSERT: begin
          if (cur_hit) begin
            status_nxt = akpt_pkg::ST_DUP;
          end else if (cur_valid) begin
            status_nxt = akpt_pkg::ST_FULL;
          end else begin
            wr.en          = 1'b1;
            valid_nxt[pos_r] = 1'b1;
          end
        end
        akpt_pkg::REQ_REMOVE: begin
          if (cur_hit) begin
            freed_fr_nxt     = rd_data.frames;
            freed_hd_nxt     = rd_data.handle;
            valid_nxt[pos_r] = 1'b0;
          end else begin
            status_nxt = akpt_pkg::ST_MISS;
          end
        end
        akpt_pkg::REQ_CLEAR: begin
          valid_nxt = '0;
        end
        default: ;  // unused code: no change, status ok
      endcase
    end
  end

  akpt_slot_mem u_slot_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= akpt_pkg::S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= rd_addr;
    status_r   <= status_nxt;
    freed_fr_r <= freed_fr_nxt;
    freed_hd_r <= freed_hd_nxt;
    if (in_fire) begin
      req_r    <= in_req.req_type;
      key_r    <= key_in;
      home_r   <= key_in[akpt_pkg::IDX_W-1:0];
      frames_r <= in_req.frame_count;
      handle_r <= in_req.stack_handle;
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.status            = status_r;
  assign out_rsp.freed_frame_count = freed_fr_r;
  assign out_rsp.freed_handle      = freed_hd_r;

  // a finished clear leaves the table empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    finish && (req_r == akpt_pkg::REQ_CLEAR) |=> (valid_r == '0))
    else $error("clear left a valid slot");

  // a stored insert marks its slot valid
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_r[$past(wr.addr)])
    else $error("insert did not mark slot valid");

  // only a successful remove returns nonzero freed fields
  a_freed_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != akpt_pkg::ST_OK) |->
      (freed_fr_r == '0) && (freed_hd_r == '0))
    else $error("freed fields set on failed request");

  // a probe never finishes into a result register that is still full
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !out_valid_r || out_rsp.ready)
    else $error("result overwritten before it was taken");

endmodule

FILE: rtl/core/akpt_slot_mem.sv
// Slot payload storage (key, frame count, handle): one write port, one registered read port.
// Depends on akpt_pkg.
module akpt_slot_mem (
  input  logic              clk,
  input  akpt_pkg::slot_wr_t wr,
  input  akpt_pkg::slot_t   wr_data,
  input  akpt_pkg::idx_t    rd_addr,
  output akpt_pkg::slot_t   rd_data
);

  akpt_pkg::slot_t mem [akpt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: bench/address_keyed_linear_probe_table_core_tb.sv
`timescale 1ns / 1ps
// Testbench for address_keyed_linear_probe_table_core: directed and random table requests.
// It uses akpt_pkg, akpt_req_if and akpt_rsp_if, and keeps its own table to predict each result.
module address_keyed_linear_probe_table_core_tb;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;   // no such request; block answers ok
  localparam int         RANDOM_ITEMS = 1560;
  localparam int         TAIL_CYCLES  = 80;     // past the longest probe
  localparam int         STALL_LIMIT  = 2000;
  localparam int         TAG_W        = akpt_pkg::ADDR_W - akpt_pkg::IDX_W;

  typedef struct packed {
    akpt_pkg::status_t status;
    akpt_pkg::frame_t  frames;
    akpt_pkg::handle_t handle;
  } result_t;

  logic clk;
  logic rst_n;

  akpt_req_if req_ch ();
  akpt_rsp_if rsp_ch ();

  address_keyed_linear_probe_table_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // predicted table contents
  logic              tbl_valid  [akpt_pkg::TABLE_DEPTH];
  akpt_pkg::key_t    tbl_key    [akpt_pkg::TABLE_DEPTH];
  akpt_pkg::frame_t  tbl_frames [akpt_pkg::TABLE_DEPTH];
  akpt_pkg::handle_t tbl_handle [akpt_pkg::TABLE_DEPTH];

  result_t     pending_results[$];
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned kind_sent [4];
  int unsigned status_seen [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  function automatic void tbl_clear();
    for (int i = 0; i < akpt_pkg::TABLE_DEPTH; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_key[i]    = '0;
      tbl_frames[i] = '0;
      tbl_handle[i] = '0;
    end
  endfunction

  // Linear probe from the home slot; stops on empty, on a match, or back at home.
  function automatic bit probe_slots(akpt_pkg::key_t key, output akpt_pkg::idx_t stop);
    akpt_pkg::idx_t home;
    akpt_pkg::idx_t pos;
    bit             hit;
    home = key[akpt_pkg::IDX_W-1:0];
    pos  = home;
    hit  = 1'b0;
    while (tbl_valid[pos]) begin
      if (tbl_key[pos] == key) begin
        hit = 1'b1;
        break;
      end
      pos = pos + 1'b1;
      if (pos == home) break;
    end
    stop = pos;
    return hit;
  endfunction

  function automatic result_t table_apply(logic [1:0] kind,
                                          logic [akpt_pkg::ADDR_W-1:0] addr,
                                          akpt_pkg::frame_t frames,
                                          akpt_pkg::handle_t handle);
    result_t        r;
    akpt_pkg::key_t key;
    akpt_pkg::idx_t pos;
    r.status = akpt_pkg::ST_OK;
    r.frames = '0;
    r.handle = '0;
    key = addr[akpt_pkg::KEY_BITS-1:0];
    case (kind)
      akpt_pkg::REQ_INSERT: begin
        if (probe_slots(key, pos)) begin
          r.status = akpt_pkg::ST_DUP;
        end else if (tbl_valid[pos]) begin
          r.status = akpt_pkg::ST_FULL;
        end else begin
          tbl_valid[pos]  = 1'b1;
          tbl_key[pos]    = key;
          tbl_frames[pos] = frames;
          tbl_handle[pos] = handle;
        end
      end
      akpt_pkg::REQ_REMOVE: begin
        if (!probe_slots(key, pos)) begin
          r.status = akpt_pkg::ST_MISS;
        end else begin
          r.frames        = tbl_frames[pos];
          r.handle        = tbl_handle[pos];
          tbl_valid[pos]  = 1'b0;
          tbl_key[pos]    = '0;
          tbl_frames[pos] = '0;
          tbl_handle[pos] = '0;
        end
      end
      akpt_pkg::REQ_CLEAR: tbl_clear();
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [akpt_pkg::ADDR_W-1:0] rand_address();
    return akpt_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  // Random address whose home slot falls in a window of the given width.
  function automatic logic [akpt_pkg::ADDR_W-1:0] fresh_address(akpt_pkg::idx_t base,
                                                                int unsigned spread);
    logic [akpt_pkg::ADDR_W-1:0] a;
    a = rand_address();
    case ($urandom_range(0, 9))
      0:       a[akpt_pkg::ADDR_W-1:akpt_pkg::IDX_W] = '1;
      1, 2, 3: a[akpt_pkg::ADDR_W-1:akpt_pkg::IDX_W] = TAG_W'($urandom_range(0, 15));
      default: ;
    endcase
    a[akpt_pkg::IDX_W-1:0] = base + akpt_pkg::idx_t'($urandom_range(0, spread - 1));
    return a;
  endfunction

  function automatic bit stored_address(output logic [akpt_pkg::ADDR_W-1:0] addr);
    akpt_pkg::idx_t live[$];
    addr = '0;
    for (int i = 0; i < akpt_pkg::TABLE_DEPTH; i++) begin
      if (tbl_valid[i]) live.push_back(akpt_pkg::idx_t'(i));
    end
    if (live.size() == 0) return 1'b0;
    addr = akpt_pkg::ADDR_W'(tbl_key[live[$urandom_range(0, live.size() - 1)]]);
    return 1'b1;
  endfunction

  // One request beat, paced in bursts; the prediction is made when the beat is taken.
  task automatic send_req(logic [1:0] kind, logic [akpt_pkg::ADDR_W-1:0] addr,
                          akpt_pkg::frame_t frames, akpt_pkg::handle_t handle);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.address      <= addr;
    req_ch.frame_count  <= frames;
    req_ch.stack_handle <= handle;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(table_apply(kind, addr, frames, handle));
    kind_sent[kind]++;
  endtask

  // Hold off the sender until every outstanding result has been taken.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    logic [akpt_pkg::ADDR_W-1:0] all_ones;
    all_ones = '1;
    send_req(akpt_pkg::REQ_INSERT, '0, '0, '0);
    send_req(akpt_pkg::REQ_INSERT, all_ones, '1, '1);
    send_req(akpt_pkg::REQ_INSERT, all_ones, 7'h2A, 32'h1234_5678);  // duplicate key
    send_req(akpt_pkg::REQ_REMOVE, 48'h1234_5678_9ABC, '0, '0);      // absent key
    send_req(akpt_pkg::REQ_REMOVE, all_ones, '0, '0);
    send_req(akpt_pkg::REQ_REMOVE, '0, '1, '1);
    send_req(akpt_pkg::REQ_REMOVE, '0, '0, '0);
    send_req(REQ_UNUSED, rand_address(), 7'($urandom), $urandom);
  endtask

  task automatic test_chain_break();
    logic [akpt_pkg::ADDR_W-1:0] ka, kb, kc, kw, step;
    step = akpt_pkg::ADDR_W'(akpt_pkg::TABLE_DEPTH);
    ka = 48'h0000_1000_0005;
    kb = ka + step;
    kc = kb + step;
    kw = 48'h0000_2000_003F;
    send_req(akpt_pkg::REQ_INSERT, ka, 7'd1, 32'hA000_0001);
    send_req(akpt_pkg::REQ_INSERT, kb, 7'd2, 32'hA000_0002);
    send_req(akpt_pkg::REQ_INSERT, kc, 7'd3, 32'hA000_0003);
    send_req(akpt_pkg::REQ_REMOVE, kb, '0, '0);
    send_req(akpt_pkg::REQ_REMOVE, kc, '0, '0);  // hole ends the probe before kc
    send_req(akpt_pkg::REQ_INSERT, kc, 7'd4, 32'hA000_0004);
    send_req(akpt_pkg::REQ_REMOVE, ka, '0, '0);
    send_req(akpt_pkg::REQ_REMOVE, kc, '0, '0);
    // probe wraps from the last slot to slot zero
    send_req(akpt_pkg::REQ_INSERT, kw, 7'd5, 32'hB000_0005);
    send_req(akpt_pkg::REQ_INSERT, kw + step, 7'd6, 32'hB000_0006);
    send_req(akpt_pkg::REQ_REMOVE, kw + step, '0, '0);
    send_req(akpt_pkg::REQ_REMOVE, kw, '0, '0);
  endtask

  task automatic test_clear_all();
    send_req(akpt_pkg::REQ_INSERT, 48'h0000_3000_0011, 7'd9, 32'hC000_0009);
    send_req(akpt_pkg::REQ_CLEAR, rand_address(), 7'($urandom), $urandom);
    send_req(akpt_pkg::REQ_REMOVE, 48'h0000_3000_0011, '0, '0);
    send_req(akpt_pkg::REQ_CLEAR, '0, '0, '0);
  endtask

  task automatic test_full_table();
    logic [akpt_pkg::ADDR_W-1:0] keys [akpt_pkg::TABLE_DEPTH];
    logic [akpt_pkg::ADDR_W-1:0] a;
    for (int i = 0; i < akpt_pkg::TABLE_DEPTH; i++) begin
      a = rand_address();
      a[2*akpt_pkg::IDX_W-1:akpt_pkg::IDX_W] = akpt_pkg::idx_t'(i);  // keeps keys distinct
      a[akpt_pkg::IDX_W-1:0]                 = akpt_pkg::idx_t'($urandom_range(0, 7));
      keys[i] = a;
      send_req(akpt_pkg::REQ_INSERT, a, 7'($urandom), $urandom);
    end
    send_req(akpt_pkg::REQ_INSERT, keys[0] ^ (48'h1 << 40), 7'd1, 32'h1);
    send_req(akpt_pkg::REQ_INSERT, keys[akpt_pkg::TABLE_DEPTH-1], 7'd2, 32'h2);
    send_req(akpt_pkg::REQ_REMOVE, keys[5] ^ (48'h1 << 41), '0, '0);
    send_req(akpt_pkg::REQ_REMOVE, keys[17], '0, '0);
    send_req(akpt_pkg::REQ_INSERT, keys[17] ^ (48'h1 << 42), 7'd3, 32'h3);
    send_req(akpt_pkg::REQ_CLEAR, '0, '0, '0);
  endtask

  task automatic test_random_traffic(int unsigned target);
    int unsigned                 done;
    int unsigned                 round;
    int unsigned                 len;
    int unsigned                 spread;
    int unsigned                 ins_pct;
    int unsigned                 roll;
    akpt_pkg::idx_t              base;
    logic [akpt_pkg::ADDR_W-1:0] a;
    done  = 0;
    round = 0;
    while (done < target) begin
      base = akpt_pkg::idx_t'($urandom);
      case ($urandom_range(0, 3))
        0:       spread = 1;
        1:       spread = 2;
        2:       spread = 8;
        default: spread = akpt_pkg::TABLE_DEPTH;
      endcase
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 55;
        default: ins_pct = 30;
      endcase
      len = $urandom_range(30, 150);
      if ($urandom_range(0, 3) == 0) begin
        send_req(akpt_pkg::REQ_CLEAR, rand_address(), 7'($urandom), $urandom);
        done++;
      end
      for (int n = 0; n < len && done < target; n++) begin
        roll = $urandom_range(0, 199);
        if (roll < 3) begin
          send_req(REQ_UNUSED, rand_address(), 7'($urandom), $urandom);
        end else begin
          done++;
          if (roll == 3) begin
            send_req(akpt_pkg::REQ_CLEAR, rand_address(), 7'($urandom), $urandom);
          end else if ($urandom_range(0, 99) < ins_pct) begin
            if ($urandom_range(0, 9) != 0 || !stored_address(a)) a = fresh_address(base, spread);
            send_req(akpt_pkg::REQ_INSERT, a, 7'($urandom), $urandom);
          end else begin
            if ($urandom_range(0, 3) == 0 || !stored_address(a)) a = fresh_address(base, spread);
            send_req(akpt_pkg::REQ_REMOVE, a, 7'($urandom), $urandom);
          end
        end
      end
      round++;
      if (round % 5 == 0) drain_results();
    end
  endtask

  // result side: stalls come in modes that a mode timer picks anew at random
  initial begin
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned mode_timer;
    stall_left = 0;
    stall_mode = 0;
    mode_timer = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (++mode_timer == 600) begin
        mode_timer = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 3);
        end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(4, 24);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending, status", 64'(rsp_ch.status), '0);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
        if (rsp_ch.freed_frame_count !== want.frames)
          report_mismatch("freed_frame_count", 64'(rsp_ch.freed_frame_count), 64'(want.frames));
        if (rsp_ch.freed_handle !== want.handle)
          report_mismatch("freed_handle", 64'(rsp_ch.freed_handle), 64'(want.handle));
      end
    end
  end

  // ends the run once no beat has moved on either side for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles, %0d results pending",
             STALL_LIMIT, pending_results.size());
    $display("FAIL address_keyed_linear_probe_table_core");
    $finish;
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    for (int i = 0; i < 4; i++) begin
      kind_sent[i]   = 0;
      status_seen[i] = 0;
    end
    tbl_clear();
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= akpt_pkg::REQ_INSERT;
    req_ch.address      <= '0;
    req_ch.frame_count  <= '0;
    req_ch.stack_handle <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_chain_break();
    test_clear_all();
    drain_results();
    test_full_table();
    test_random_traffic(RANDOM_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), '0);
    $display("sent %0d inserts, %0d removes, %0d clears, %0d unused codes",
             kind_sent[akpt_pkg::REQ_INSERT], kind_sent[akpt_pkg::REQ_REMOVE],
             kind_sent[akpt_pkg::REQ_CLEAR], kind_sent[REQ_UNUSED]);
    $display("results: %0d ok, %0d duplicate, %0d full, %0d not found; %0d mismatches",
             status_seen[akpt_pkg::ST_OK], status_seen[akpt_pkg::ST_DUP],
             status_seen[akpt_pkg::ST_FULL], status_seen[akpt_pkg::ST_MISS], mismatches);
    if (mismatches == 0) begin
      $display("PASS address_keyed_linear_probe_table_core");
    end else begin
      $display("FAIL address_keyed_linear_probe_table_core");
    end
    $finish;
  end

endmodule
